// ===== hw/rtl/ple_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int OP_WIDTH     = 2;
   localparam int POS_WIDTH    = 7;
   localparam int VALUE_WIDTH  = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int LENGTH_WIDTH = 7;

   // operation codes
   localparam logic [OP_WIDTH-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_DUMP   = 2'd2;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_BADPOS = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY  = 2'd3;

   typedef struct packed {
      logic [OP_WIDTH-1:0]           op;
      logic [POS_WIDTH-1:0]          position;
      logic signed [VALUE_WIDTH-1:0] item_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] element;
      logic [STATUS_WIDTH-1:0]       status;
      logic [LENGTH_WIDTH-1:0]       length;
      logic                          last;
   } rsp_payload_type;

   typedef enum logic [0:0] {
      S_IDLE,
      S_DUMP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic                    insert;
      logic                    delete;
      logic                    rotate;
      logic                    load;
      logic                    elem_sel;
      logic [STATUS_WIDTH-1:0] status;
      logic                    last;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ins_pos_ok;
      logic del_pos_ok;
      logic full;
      logic empty;
      logic single;
   } dp_status_type;

endpackage

// ===== hw/rtl/positional_list_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list edited by 1-based position, with insert, delete and dump.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation (insert, delete, dump) per transfer; rsp_*
//   returns results. A transfer happens when valid is high and stall low.
//   Insert and delete shift the cell row and give one status result with the
//   new length, registered in the cycle after the transfer. Back-to-back
//   inserts/deletes run at one item per cycle while rsp_stall is low.
//   A dump of n elements streams n results, one per cycle while rsp_stall is
//   low, by rotating the first n cells through cell 0; the last carries
//   last=1. req_stall stays high until the final dump result is loaded.
//   An empty dump gives one empty-status result. Op code 3 is dropped.
//   Result rate is set by the single output register: while rsp_stall is
//   high the result holds and req_stall is raised; nothing is lost.
//   Reset clears the count and pending result; cell contents are left as
//   they are and are never read before being written.
// ----------------------------------------------------------------------------
module positional_list_engine_core #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ple_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ple_pkg::rsp_payload_type rsp_payload
);

   localparam int CW = $clog2(CAPACITY + 1);

   ple_pkg::dp_cmd_type    cmd;
   ple_pkg::dp_status_type status;
   logic [CW-1:0]          count;

   ple_ctrl #(
      .CW (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_payload.op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .count     (count),
      .cmd       (cmd)
   );

   ple_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .count       (count),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hw/rtl/ple_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_datapath
// Shifting cell row holding the list, element count and result register.
// ----------------------------------------------------------------------------
module ple_datapath #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32,
   parameter int CW         = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ple_pkg::req_payload_type req_payload,
   input  ple_pkg::dp_cmd_type      cmd,
   output ple_pkg::dp_status_type   status,
   output logic [CW-1:0]            count,
   output ple_pkg::rsp_payload_type rsp_payload
);

   logic [DATA_WIDTH-1:0]    cells_ff [CAPACITY];
   logic [DATA_WIDTH-1:0]    cells_in [CAPACITY];
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   ple_pkg::rsp_payload_type rsp_ff;
   ple_pkg::rsp_payload_type rsp_in;
   logic [7:0]               pos8;
   logic [7:0]               pos_m1;
   logic [7:0]               cnt8;
   logic [DATA_WIDTH-1:0]    new_val;

   assign pos8    = 8'(req_payload.position);
   assign pos_m1  = pos8 - 8'd1;
   assign cnt8    = 8'(count_ff);
   assign new_val = DATA_WIDTH'(req_payload.item_value);

   assign status.ins_pos_ok = (pos8 != 8'd0) && (pos8 <= cnt8 + 8'd1);
   assign status.del_pos_ok = (pos8 != 8'd0) && (pos8 <= cnt8);
   assign status.full       = (count_ff == CW'(CAPACITY));
   assign status.empty      = (count_ff == '0);
   assign status.single     = (count_ff == CW'(1));

   assign count       = count_ff;
   assign rsp_payload = rsp_ff;

   // each cell picks from itself, a neighbor, cell 0 (rotate wrap) or the new value
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (cmd.insert) begin
            if (8'(i) == pos_m1) begin
               cells_in[i] = new_val;
            end else if (8'(i) > pos_m1 && 8'(i) <= cnt8) begin
               cells_in[i] = cells_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (cmd.delete) begin
            if (8'(i) >= pos_m1 && 8'(i) + 8'd1 < cnt8) begin
               cells_in[i] = cells_ff[(i == CAPACITY - 1) ? i : i + 1];
            end
         end else if (cmd.rotate) begin
            if (8'(i) + 8'd1 < cnt8) begin
               cells_in[i] = cells_ff[(i == CAPACITY - 1) ? i : i + 1];
            end else if (8'(i) + 8'd1 == cnt8) begin
               cells_in[i] = cells_ff[0];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.delete) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load) begin
         rsp_in.element = cmd.elem_sel ? 32'($signed(cells_ff[0])) : '0;
         rsp_in.status  = cmd.status;
         rsp_in.length  = ple_pkg::LENGTH_WIDTH'(count_in);
         rsp_in.last    = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      rsp_ff   <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> (!status.full && status.ins_pos_ok))
      else $error("insert applied to full list or bad position");

   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      cmd.delete |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("delete did not shrink the count");

endmodule

// ===== hw/rtl/ple_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Operation sequencer: decodes requests, runs dump streaming, owns rsp_valid.
// ----------------------------------------------------------------------------
module ple_ctrl #(
   parameter int CW = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ple_pkg::OP_WIDTH-1:0]  req_op,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  ple_pkg::dp_status_type        status,
   input  logic [CW-1:0]                 count,
   output ple_pkg::dp_cmd_type           cmd
);

   ple_pkg::state_type state_ff;
   ple_pkg::state_type state_in;
   logic [CW-1:0]      dump_cnt_ff;
   logic [CW-1:0]      dump_cnt_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;
   logic               req_fire;
   logic               dump_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == ple_pkg::S_DUMP) || !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign dump_last = (dump_cnt_ff + CW'(1)) == count;

   always_comb begin
      state_in     = state_ff;
      dump_cnt_in  = dump_cnt_ff;
      cmd          = '0;
      cmd.status   = ple_pkg::ST_OK;
      unique case (state_ff)
         ple_pkg::S_IDLE: begin
            if (req_fire) begin
               cmd.last = 1'b1;
               unique case (req_op)
                  ple_pkg::OP_INSERT: begin
                     cmd.load = 1'b1;
                     if (!status.ins_pos_ok) begin
                        cmd.status = ple_pkg::ST_BADPOS;
                     end else if (status.full) begin
                        cmd.status = ple_pkg::ST_FULL;
                     end else begin
                        cmd.insert = 1'b1;
                     end
                  end
                  ple_pkg::OP_DELETE: begin
                     cmd.load = 1'b1;
                     if (!status.del_pos_ok) begin
                        cmd.status = ple_pkg::ST_BADPOS;
                     end else begin
                        cmd.delete = 1'b1;
                     end
                  end
                  ple_pkg::OP_DUMP: begin
                     cmd.load = 1'b1;
                     if (status.empty) begin
                        cmd.status = ple_pkg::ST_EMPTY;
                     end else begin
                        cmd.elem_sel = 1'b1;
                        cmd.rotate   = 1'b1;
                        cmd.last     = status.single;
                        if (!status.single) begin
                           dump_cnt_in = CW'(1);
                           state_in    = ple_pkg::S_DUMP;
                        end
                     end
                  end
                  default: begin
                     cmd.last = 1'b0;  // unused code: dropped
                  end
               endcase
            end
         end
         ple_pkg::S_DUMP: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               cmd.elem_sel = 1'b1;
               cmd.rotate   = 1'b1;
               cmd.last     = dump_last;
               dump_cnt_in  = dump_cnt_ff + CW'(1);
               if (dump_last) begin
                  state_in = ple_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = ple_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ple_pkg::S_IDLE;
         dump_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dump_cnt_ff  <= dump_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_dump_holds_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ple_pkg::S_DUMP) |-> rsp_valid_ff)
      else $error("dump in progress without a pending result");

   a_one_edit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.insert, cmd.delete, cmd.rotate}))
      else $error("more than one list edit in a cycle");

   a_dump_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ple_pkg::S_DUMP) |-> (dump_cnt_ff < count))
      else $error("dump index ran past the count");

endmodule
